// File: hw/rtl/pbrs_pkg.sv
`default_nettype none
package pbrs_pkg;

  localparam int PRIO_LEVELS = 32;
  localparam int MAX_THREADS = 32;

  localparam int ID_W = 5;
  localparam int PRIO_W = 5;
  localparam int LINK_W = 6;
  localparam int MASK_W = 32;
  localparam int SLOTS = 32;

  localparam logic [LINK_W-1:0] LINK_NONE = 6'd63;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SCHEDULE = 2'd2;
  localparam logic [1:0] MODE_START = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NONE_READY = 2'd1;
  localparam logic [1:0] STATUS_INSERT_IGNORED = 2'd2;
  localparam logic [1:0] STATUS_REMOVE_IGNORED = 2'd3;

  typedef logic [LINK_W-1:0] link_t;

  function automatic logic [PRIO_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
    logic [PRIO_W-1:0] n;
    n = PRIO_W'(MASK_W - 1);
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        n = PRIO_W'(i);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pbrs_if.sv
`default_nettype none
interface pbrs_req_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [pbrs_pkg::ID_W-1:0] thread_id;
  logic [pbrs_pkg::PRIO_W-1:0] thread_priority;

  modport source (output valid, mode, thread_id, thread_priority, input ready);
  modport sink (input valid, mode, thread_id, thread_priority, output ready);
endinterface

interface pbrs_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic switched;
  logic has_from;
  logic [pbrs_pkg::ID_W-1:0] from_id;
  logic [pbrs_pkg::ID_W-1:0] to_id;
  logic [pbrs_pkg::PRIO_W-1:0] active_level;
  logic [pbrs_pkg::MASK_W-1:0] ready_mask;

  modport source (output valid, status, switched, has_from, from_id, to_id,
                  active_level, ready_mask, input ready);
  modport sink (input valid, status, switched, has_from, from_id, to_id,
                active_level, ready_mask, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/priority_bitmap_ready_scheduler_unit.sv
// Ready queue of a hardware RTOS scheduler: one FIFO of thread ids per
// priority level, kept as linked lists, and a bitmap of nonempty levels.
// Requests arrive on req as beats of mode, thread_id and thread_priority:
// insert, remove, schedule or start. Every request gives exactly one beat on
// rsp with a status, the switch report and the bitmap after the request.
// A request beat is held in an input register, where the link update or the
// priority encode of the bitmap is worked out, and its result is written to
// the output register when that register is empty or its beat is taken. One
// request is taken in every cycle while rsp keeps up; the rate is set by the
// single pass through the link tables between the two registers.
// Reset empties every level, clears the bitmap and leaves no current thread.
// When the receiver stalls, the result stays in the output register and one
// more request may wait in the input register; req.ready then falls until
// the result beat is taken.
`default_nettype none
module priority_bitmap_ready_scheduler_unit (
  input wire logic clk,
  input wire logic rst,
  pbrs_req_if.sink req,
  pbrs_rsp_if.source rsp
);

  logic s_valid;
  logic [1:0] s_mode;
  logic [pbrs_pkg::ID_W-1:0] s_id;
  logic [pbrs_pkg::PRIO_W-1:0] s_prio;

  pbrs_pkg::link_t next_link [pbrs_pkg::SLOTS];
  pbrs_pkg::link_t prev_link [pbrs_pkg::SLOTS];
  logic [pbrs_pkg::SLOTS-1:0] is_queued;
  logic [pbrs_pkg::PRIO_W-1:0] queued_priority [pbrs_pkg::SLOTS];
  pbrs_pkg::link_t level_head [pbrs_pkg::SLOTS];
  pbrs_pkg::link_t level_tail [pbrs_pkg::SLOTS];
  logic [pbrs_pkg::MASK_W-1:0] ready_bitmap;
  pbrs_pkg::link_t current_id;
  logic [pbrs_pkg::PRIO_W-1:0] current_level;

  logic fire;
  logic id_ok;
  logic [pbrs_pkg::PRIO_W-1:0] prio_sat;
  logic [pbrs_pkg::PRIO_W-1:0] rem_lv;
  pbrs_pkg::link_t rem_p;
  pbrs_pkg::link_t rem_n;
  pbrs_pkg::link_t ins_tail;
  logic [pbrs_pkg::PRIO_W-1:0] sched_lv;
  pbrs_pkg::link_t sched_head;
  logic ins_ok;
  logic rem_ok;
  logic [1:0] status_c;
  logic switched_c;
  logic has_from_c;
  logic [pbrs_pkg::ID_W-1:0] from_c;
  logic [pbrs_pkg::ID_W-1:0] to_c;
  logic [pbrs_pkg::MASK_W-1:0] ready_bitmap_next;
  pbrs_pkg::link_t current_id_next;
  logic [pbrs_pkg::PRIO_W-1:0] current_level_next;

  assign fire = s_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s_valid || fire;

  assign id_ok = {1'b0, s_id} < (pbrs_pkg::ID_W + 1)'(pbrs_pkg::MAX_THREADS);
  assign prio_sat = ({1'b0, s_prio} >= (pbrs_pkg::PRIO_W + 1)'(pbrs_pkg::PRIO_LEVELS)) ?
                    pbrs_pkg::PRIO_W'(pbrs_pkg::PRIO_LEVELS - 1) : s_prio;
  assign rem_lv = queued_priority[s_id];
  assign rem_p = prev_link[s_id];
  assign rem_n = next_link[s_id];
  assign ins_tail = level_tail[prio_sat];
  assign sched_lv = pbrs_pkg::lowest_set(ready_bitmap);
  assign sched_head = level_head[sched_lv];

  always_comb begin
    status_c = pbrs_pkg::STATUS_OK;
    switched_c = 1'b0;
    has_from_c = 1'b0;
    from_c = '0;
    to_c = '0;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    ready_bitmap_next = ready_bitmap;
    current_id_next = current_id;
    current_level_next = current_level;
    case (s_mode)
      pbrs_pkg::MODE_INSERT: begin
        if (!id_ok || is_queued[s_id]) begin
          status_c = pbrs_pkg::STATUS_INSERT_IGNORED;
        end else begin
          ins_ok = 1'b1;
          ready_bitmap_next = ready_bitmap | (pbrs_pkg::MASK_W'(1) << prio_sat);
        end
      end
      pbrs_pkg::MODE_REMOVE: begin
        if (!id_ok || !is_queued[s_id]) begin
          status_c = pbrs_pkg::STATUS_REMOVE_IGNORED;
        end else begin
          rem_ok = 1'b1;
          if (rem_p == pbrs_pkg::LINK_NONE && rem_n == pbrs_pkg::LINK_NONE) begin
            ready_bitmap_next = ready_bitmap & ~(pbrs_pkg::MASK_W'(1) << rem_lv);
          end
        end
      end
      default: begin
        if (ready_bitmap == '0) begin
          status_c = pbrs_pkg::STATUS_NONE_READY;
        end else if (s_mode == pbrs_pkg::MODE_START) begin
          current_id_next = sched_head;
          switched_c = 1'b1;
          to_c = sched_head[pbrs_pkg::ID_W-1:0];
        end else if (sched_head != current_id) begin
          if (current_id != pbrs_pkg::LINK_NONE) begin
            has_from_c = 1'b1;
            from_c = current_id[pbrs_pkg::ID_W-1:0];
          end
          current_level_next = sched_lv;
          current_id_next = sched_head;
          switched_c = 1'b1;
          to_c = sched_head[pbrs_pkg::ID_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      rsp.valid <= 1'b0;
      for (int i = 0; i < pbrs_pkg::SLOTS; i++) begin
        next_link[i] <= pbrs_pkg::LINK_NONE;
        prev_link[i] <= pbrs_pkg::LINK_NONE;
        level_head[i] <= pbrs_pkg::LINK_NONE;
        level_tail[i] <= pbrs_pkg::LINK_NONE;
      end
      is_queued <= '0;
      ready_bitmap <= '0;
      current_id <= pbrs_pkg::LINK_NONE;
      current_level <= pbrs_pkg::PRIO_W'(pbrs_pkg::PRIO_LEVELS - 1);
    end else begin
      if (req.valid && req.ready) begin
        s_valid <= 1'b1;
        s_mode <= req.mode;
        s_id <= req.thread_id;
        s_prio <= req.thread_priority;
      end else if (fire) begin
        s_valid <= 1'b0;
      end

      if (fire) begin
        rsp.valid <= 1'b1;
        rsp.status <= status_c;
        rsp.switched <= switched_c;
        rsp.has_from <= has_from_c;
        rsp.from_id <= from_c;
        rsp.to_id <= to_c;
        rsp.active_level <= current_level_next;
        rsp.ready_mask <= ready_bitmap_next;
        ready_bitmap <= ready_bitmap_next;
        current_id <= current_id_next;
        current_level <= current_level_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      if (fire && ins_ok) begin
        if (ready_bitmap[prio_sat]) begin
          next_link[ins_tail[pbrs_pkg::ID_W-1:0]] <= pbrs_pkg::link_t'(s_id);
          prev_link[s_id] <= ins_tail;
        end else begin
          level_head[prio_sat] <= pbrs_pkg::link_t'(s_id);
          prev_link[s_id] <= pbrs_pkg::LINK_NONE;
        end
        next_link[s_id] <= pbrs_pkg::LINK_NONE;
        level_tail[prio_sat] <= pbrs_pkg::link_t'(s_id);
        is_queued[s_id] <= 1'b1;
        queued_priority[s_id] <= prio_sat;
      end

      if (fire && rem_ok) begin
        if (rem_p == pbrs_pkg::LINK_NONE) begin
          level_head[rem_lv] <= rem_n;
        end else begin
          next_link[rem_p[pbrs_pkg::ID_W-1:0]] <= rem_n;
        end
        if (rem_n == pbrs_pkg::LINK_NONE) begin
          level_tail[rem_lv] <= rem_p;
        end else begin
          prev_link[rem_n[pbrs_pkg::ID_W-1:0]] <= rem_p;
        end
        next_link[s_id] <= pbrs_pkg::LINK_NONE;
        prev_link[s_id] <= pbrs_pkg::LINK_NONE;
        is_queued[s_id] <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/pbrs_checker.sv
`default_nettype none
module pbrs_checker import pbrs_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  pbrs_req_if req,
  pbrs_rsp_if rsp,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] status;
    logic switched;
    logic has_from;
    logic [ID_W-1:0] from_id;
    logic [ID_W-1:0] to_id;
    logic [PRIO_W-1:0] cur_prio;
    logic [MASK_W-1:0] mask;
  } sched_result_t;

  link_t next_of[SLOTS];
  link_t prev_of[SLOTS];
  logic queued[SLOTS];
  logic [PRIO_W-1:0] level_of[SLOTS];
  link_t head_of[PRIO_LEVELS];
  link_t tail_of[PRIO_LEVELS];
  logic [MASK_W-1:0] ready_bits;
  link_t cur_id;
  logic [PRIO_W-1:0] cur_level;

  sched_result_t results_due[$];
  sched_result_t want;

  function automatic void clear_ready_queue();
    foreach (next_of[i]) begin
      next_of[i] = LINK_NONE;
      prev_of[i] = LINK_NONE;
      queued[i] = 1'b0;
      level_of[i] = '0;
    end
    foreach (head_of[i]) begin
      head_of[i] = LINK_NONE;
      tail_of[i] = LINK_NONE;
    end
    ready_bits = '0;
    cur_id = LINK_NONE;
    cur_level = PRIO_W'(PRIO_LEVELS - 1);
  endfunction

  function automatic sched_result_t apply_request(logic [1:0] mode, logic [ID_W-1:0] id,
                                                  logic [PRIO_W-1:0] prio);
    sched_result_t r;
    logic [PRIO_W-1:0] lv;
    link_t p;
    link_t n;
    int k;
    r = '0;
    r.status = STATUS_OK;
    case (mode)
      MODE_INSERT: begin
        if (int'(id) >= MAX_THREADS || queued[id]) begin
          r.status = STATUS_INSERT_IGNORED;
        end else begin
          lv = (int'(prio) >= PRIO_LEVELS) ? PRIO_W'(PRIO_LEVELS - 1) : prio;
          p = tail_of[lv];
          if (ready_bits[lv]) begin
            next_of[p[ID_W-1:0]] = link_t'(id);
            prev_of[id] = p;
          end else begin
            head_of[lv] = link_t'(id);
            prev_of[id] = LINK_NONE;
          end
          next_of[id] = LINK_NONE;
          tail_of[lv] = link_t'(id);
          queued[id] = 1'b1;
          level_of[id] = lv;
          ready_bits[lv] = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (int'(id) >= MAX_THREADS || !queued[id]) begin
          r.status = STATUS_REMOVE_IGNORED;
        end else begin
          lv = level_of[id];
          p = prev_of[id];
          n = next_of[id];
          if (p == LINK_NONE) head_of[lv] = n;
          else next_of[p[ID_W-1:0]] = n;
          if (n == LINK_NONE) tail_of[lv] = p;
          else prev_of[n[ID_W-1:0]] = p;
          next_of[id] = LINK_NONE;
          prev_of[id] = LINK_NONE;
          queued[id] = 1'b0;
          if (head_of[lv] == LINK_NONE) ready_bits[lv] = 1'b0;
        end
      end
      default: begin
        if (ready_bits == '0) begin
          r.status = STATUS_NONE_READY;
        end else begin
          k = 0;
          while (k < MASK_W - 1 && !ready_bits[k]) k++;
          lv = PRIO_W'(k);
          n = head_of[lv];
          if (mode == MODE_START) begin
            cur_id = n;
            r.switched = 1'b1;
            r.to_id = n[ID_W-1:0];
          end else if (n != cur_id) begin
            if (cur_id != LINK_NONE) begin
              r.has_from = 1'b1;
              r.from_id = cur_id[ID_W-1:0];
            end
            cur_level = lv;
            cur_id = n;
            r.switched = 1'b1;
            r.to_id = n[ID_W-1:0];
          end
        end
      end
    endcase
    r.cur_prio = cur_level;
    r.mask = ready_bits;
    return r;
  endfunction

  function automatic void compare_field(string field, logic [MASK_W-1:0] exp_val,
                                        logic [MASK_W-1:0] got_val);
    if (got_val !== exp_val) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s expected %0h, got %0h", $realtime, field, exp_val, got_val);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_ready_queue();
      results_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result beat with no request outstanding", $realtime);
          end
        end else begin
          want = results_due.pop_front();
          compare_field("status", MASK_W'(want.status), MASK_W'(rsp.status));
          compare_field("switched", MASK_W'(want.switched), MASK_W'(rsp.switched));
          compare_field("has_from", MASK_W'(want.has_from), MASK_W'(rsp.has_from));
          compare_field("from_id", MASK_W'(want.from_id), MASK_W'(rsp.from_id));
          compare_field("to_id", MASK_W'(want.to_id), MASK_W'(rsp.to_id));
          compare_field("active_level", MASK_W'(want.cur_prio),
                        MASK_W'(rsp.active_level));
          compare_field("ready_mask", want.mask, rsp.ready_mask);
        end
      end
      if (req.valid && req.ready) begin
        results_due.push_back(apply_request(req.mode, req.thread_id, req.thread_priority));
      end
    end
    pending = results_due.size();
  end

endmodule
`default_nettype wire

// File: verif/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbrs_pkg::*;

  localparam int SEGMENTS = 12;
  localparam int SEGMENT_ITEMS = 130;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int errors;
  int pending;
  longint cycles = 0;
  bit calm = 1'b0;
  logic [SLOTS-1:0] queued_ids = '0;

  pbrs_req_if req_ch();
  pbrs_rsp_if rsp_ch();

  priority_bitmap_ready_scheduler_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  pbrs_checker u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .errors(errors),
    .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return int'($urandom_range(0, 18));
  endfunction

  function automatic logic [ID_W-1:0] pick_id(bit want_queued);
    int s;
    s = int'($urandom_range(0, SLOTS - 1));
    for (int i = 0; i < SLOTS; i++) begin
      if (queued_ids[(s + i) % SLOTS] == want_queued) return ID_W'((s + i) % SLOTS);
    end
    return ID_W'(s);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send(logic [1:0] mode, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.mode = mode;
    req_ch.thread_id = id;
    req_ch.thread_priority = prio;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (mode == MODE_INSERT) queued_ids[id] = 1'b1;
    if (mode == MODE_REMOVE) queued_ids[id] = 1'b0;
  endtask

  task automatic send_random();
    int r;
    logic [ID_W-1:0] id;
    logic [PRIO_W-1:0] prio;
    r = int'($urandom_range(0, 99));
    id = ID_W'($urandom);
    prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
    if (r < 5) begin
      send(2'($urandom), id, prio);
    end else if (r < 45) begin
      if ($urandom_range(0, 9) != 0) id = pick_id(1'b0);
      send(MODE_INSERT, id, prio);
    end else if (r < 75) begin
      if ($urandom_range(0, 9) != 0) id = pick_id(1'b1);
      send(MODE_REMOVE, id, prio);
    end else if (r < 93) begin
      send(MODE_SCHEDULE, id, prio);
    end else begin
      send(MODE_START, id, prio);
    end
  endtask

  initial begin : rsp_side
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_ch.ready = 1'b0;
        hold--;
      end else begin
        rsp_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) hold = draw_wait();
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_INSERT;
    req_ch.thread_id = '0;
    req_ch.thread_priority = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(MODE_SCHEDULE, ID_W'($urandom), PRIO_W'($urandom));
    send(MODE_START, ID_W'($urandom), PRIO_W'($urandom));
    send(MODE_REMOVE, 5'd3, PRIO_W'($urandom));
    send(MODE_INSERT, 5'd0, 5'd31);
    send(MODE_INSERT, 5'd31, 5'd0);
    send(MODE_INSERT, 5'd5, 5'd31);
    send(MODE_INSERT, 5'd31, 5'd7);
    send(MODE_START, ID_W'($urandom), PRIO_W'($urandom));
    send(MODE_SCHEDULE, ID_W'($urandom), PRIO_W'($urandom));
    send(MODE_INSERT, 5'd10, 5'd0);
    send(MODE_REMOVE, 5'd31, PRIO_W'($urandom));
    send(MODE_SCHEDULE, ID_W'($urandom), PRIO_W'($urandom));
    send(MODE_REMOVE, 5'd0, PRIO_W'($urandom));
    send(MODE_INSERT, 5'd0, 5'd31);
    send(MODE_INSERT, 5'd7, 5'd31);
    send(MODE_REMOVE, 5'd0, PRIO_W'($urandom));
    send(MODE_REMOVE, 5'd7, PRIO_W'($urandom));
    send(MODE_REMOVE, 5'd10, PRIO_W'($urandom));
    send(MODE_SCHEDULE, ID_W'($urandom), PRIO_W'($urandom));
    send(MODE_REMOVE, 5'd5, PRIO_W'($urandom));
    send(MODE_SCHEDULE, ID_W'($urandom), PRIO_W'($urandom));
    send(MODE_INSERT, 5'd21, 5'd16);
    send(MODE_START, ID_W'($urandom), PRIO_W'($urandom));
    send(MODE_REMOVE, 5'd21, PRIO_W'($urandom));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      calm = ($urandom_range(0, 3) == 0);
      if (seg == SEGMENTS / 2) begin
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      repeat (SEGMENT_ITEMS) send_random();
      if ($urandom_range(0, 2) == 0) begin
        while (queued_ids != '0) send(MODE_REMOVE, pick_id(1'b1), PRIO_W'($urandom));
        send(MODE_SCHEDULE, ID_W'($urandom), PRIO_W'($urandom));
        send(MODE_START, ID_W'($urandom), PRIO_W'($urandom));
      end
    end

    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
